[design/ladrc_pkg.sv]
// ----------------------------------------------------------------------------
// ladrc_pkg: shared types, constants and helpers for the LADRC speed loop
// Fixed-point formats, register codes, sequencer states and saturating math.
// ----------------------------------------------------------------------------
package ladrc_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int PERIOD_W  = 32;
  localparam int GAIN_W    = 31;
  localparam int QUO_W     = DATA_W - 1;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [DATA_W:0]   wide_t;
  typedef logic [DATA_W-1:0]        mag_t;
  typedef logic [GAIN_W-1:0]        gain_t;
  typedef logic [PERIOD_W-1:0]      period_t;

  localparam mag_t    MAG_MAX    = 32'h7FFF_FFFF;
  localparam data_t   DATA_MAX   = 32'sh7FFF_FFFF;
  localparam data_t   DATA_MIN   = 32'sh8000_0000;
  localparam period_t PERIOD_RST = 32'd4294967;
  localparam data_t   PLANT_RST  = 32'sd65536;
  localparam gain_t   GAIN_RST   = 31'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD = 3'd0,
    CFG_PLANT  = 3'd1,
    CFG_CTRL   = 3'd2,
    CFG_OBS    = 3'd3,
    CFG_LIMIT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BETA2,
    ST_BETA1E,
    ST_PLANT,
    ST_BETA2E,
    ST_D1A,
    ST_D1B,
    ST_TSD1,
    ST_TSD2,
    ST_Z1,
    ST_Z2,
    ST_U0,
    ST_WAIT,
    ST_NUM,
    ST_DIVSTART,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    wide_t a;
    wide_t b;
    logic  sh32;
  } mul_req_t;

  typedef struct packed {
    logic start;
    mag_t num_mag;
    mag_t den_mag;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic over;
  } div_stat_t;

  function automatic data_t sat_wide(wide_t v);
    data_t r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? DATA_MIN : DATA_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic data_t sat_add(data_t a, data_t b);
    return sat_wide(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic data_t sat_sub(data_t a, data_t b);
    return sat_wide(wide_t'(a) - wide_t'(b));
  endfunction

  function automatic mag_t mag(data_t v);
    mag_t r;
    if (v[DATA_W-1]) begin
      r = mag_t'(-v);
    end else begin
      r = mag_t'(v);
    end
    return r;
  endfunction

endpackage

[design/ladrc_if.sv]
// ----------------------------------------------------------------------------
// ladrc_if: request, result and register-write channels
// Valid/ready channels with source and sink modports.
// ----------------------------------------------------------------------------
interface ladrc_in_if import ladrc_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t speed_cmd;
  data_t speed_meas;
  logic  clear;

  modport source (output valid, output speed_cmd, output speed_meas, output clear,
                  input ready);
  modport sink (input valid, input speed_cmd, input speed_meas, input clear,
                output ready);
endinterface

interface ladrc_out_if import ladrc_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t drive;
  logic  limited;

  modport source (output valid, output drive, output limited, input ready);
  modport sink (input valid, input drive, input limited, output ready);
endinterface

interface ladrc_cfg_if import ladrc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/ladrc_mul.sv]
// ----------------------------------------------------------------------------
// ladrc_mul: shared fixed-point multiplier
// Sign-magnitude 32x32 product, registered, then rounded and saturated into
// a second register.
// ----------------------------------------------------------------------------
module ladrc_mul import ladrc_pkg::*; (
  input  logic     clk,
  input  mul_req_t req,
  output data_t    res
);

  localparam int PROD_W  = 2 * DATA_W;
  localparam int SHIFT_W = PROD_W + 1 - FRAC_W;

  wide_t              abs_a;
  wide_t              abs_b;
  logic [PROD_W-1:0]  prod_r;
  logic               neg_r;
  logic               sh32_r;
  logic [PROD_W:0]    rnd;
  logic [SHIFT_W-1:0] shifted;
  data_t              res_nxt;
  data_t              res_r;

  assign abs_a = req.a[DATA_W] ? -req.a : req.a;
  assign abs_b = req.b[DATA_W] ? -req.b : req.b;

  always_ff @(posedge clk) begin
    prod_r <= abs_a[DATA_W-1:0] * abs_b[DATA_W-1:0];
    neg_r  <= req.a[DATA_W] ^ req.b[DATA_W];
    sh32_r <= req.sh32;
  end

  always_comb begin
    rnd = {1'b0, prod_r} + (sh32_r ? ((PROD_W+1)'(1) << (PERIOD_W - 1))
                                   : ((PROD_W+1)'(1) << (FRAC_W - 1)));
    if (sh32_r) begin
      shifted = SHIFT_W'(rnd[PROD_W:PERIOD_W]);
    end else begin
      shifted = rnd[PROD_W:FRAC_W];
    end
    if (neg_r) begin
      if (shifted > SHIFT_W'(MAG_MAX) + SHIFT_W'(1)) begin
        res_nxt = DATA_MIN;
      end else begin
        res_nxt = data_t'(SHIFT_W'(0) - shifted);
      end
    end else begin
      if (shifted > SHIFT_W'(MAG_MAX)) begin
        res_nxt = DATA_MAX;
      end else begin
        res_nxt = data_t'(shifted[DATA_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

[design/ladrc_div.sv]
// ----------------------------------------------------------------------------
// ladrc_div: restoring divider for the drive quotient
// Forms (num << FRAC_W) / den one bit per cycle; flags quotients that
// cannot fit in QUO_W bits without iterating.
// ----------------------------------------------------------------------------
module ladrc_div import ladrc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output div_stat_t        stat,
  output logic [QUO_W-1:0] quo
);

  localparam int NUM_W  = DATA_W + FRAC_W;
  localparam int HEAD_W = NUM_W - QUO_W;
  localparam int CNT_W  = $clog2(QUO_W + 1);

  logic [NUM_W-1:0]  dvd;
  logic [HEAD_W-1:0] head;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              over_r, over_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  mag_t              rem_r, rem_nxt;
  logic [QUO_W-1:0]  low_r, low_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;

  assign dvd   = {req.num_mag, FRAC_W'(0)};
  assign head  = dvd[NUM_W-1:QUO_W];
  assign trial = {rem_r, low_r[QUO_W-1]};
  assign diff  = trial - {1'b0, req.den_mag};
  assign fits  = trial >= {1'b0, req.den_mag};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    over_nxt = over_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      if (DATA_W'(head) >= req.den_mag) begin
        done_nxt = 1'b1;
        over_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        over_nxt = 1'b0;
        cnt_nxt  = CNT_W'(QUO_W);
        rem_nxt  = DATA_W'(head);
        low_nxt  = dvd[QUO_W-1:0];
        quo_nxt  = '0;
      end
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      low_nxt = {low_r[QUO_W-2:0], 1'b0};
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    over_r <= over_nxt;
    rem_r  <= rem_nxt;
    low_r  <= low_nxt;
    quo_r  <= quo_nxt;
  end

  assign stat.done = done_r;
  assign stat.over = over_r;
  assign quo       = quo_r;

endmodule

[design/ladrc_first_order_speed.sv]
// ----------------------------------------------------------------------------
// ladrc_first_order_speed: first-order linear ADRC speed controller
// Extended state observer, P law and disturbance rejection over one
// shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one control tick per request: speed_cmd, speed_meas, clear.
//   out_ch returns one result per request: drive and limited.
//   cfg_ch writes the five tuning registers by index; write only when idle.
// Timing:
//   A normal tick runs the multiply schedule and then the divider. The divider
//   stops early when the quotient cannot fit in QUO_W bits, a zero plant gain
//   skips it, and a clear goes straight to the last step. The 31-step restoring
//   divider, one quotient bit per cycle, and the 13-step multiply schedule on
//   the single multiplier set the length of a tick. in_ch.ready is high only
//   between ticks, so a new request waits until the last one leaves its last step.
// Reset:
//   Estimates and the previous drive go to zero, registers to their defaults.
// Stall:
//   The output register holds a result until taken; a new request is still
//   accepted, and its result waits in the last step until the register frees.
// ----------------------------------------------------------------------------
module ladrc_first_order_speed import ladrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ladrc_in_if.sink    in_ch,
  ladrc_out_if.source out_ch,
  ladrc_cfg_if.sink   cfg_ch
);

  state_t   state_r, state_nxt;

  period_t  period_r;
  data_t    plant_r;
  gain_t    ctrl_r;
  gain_t    obs_r;
  gain_t    lim_r;

  data_t    z1_r, z1_nxt;
  data_t    z2_r, z2_nxt;
  data_t    u_prev_r, u_prev_nxt;

  data_t    cmd_r, cmd_nxt;
  data_t    meas_r, meas_nxt;
  data_t    e_r, e_nxt;
  data_t    beta1_r, beta1_nxt;
  data_t    beta2_r, beta2_nxt;
  data_t    m1_r, m1_nxt;
  data_t    d1_r, d1_nxt;
  data_t    d2_r, d2_nxt;
  data_t    cdiff_r, cdiff_nxt;
  data_t    num_r, num_nxt;
  data_t    res_drive_r, res_drive_nxt;
  logic     res_lim_r, res_lim_nxt;

  logic     out_valid_r, out_valid_nxt;
  data_t    out_drive_r, out_drive_nxt;
  logic     out_lim_r, out_lim_nxt;

  mul_req_t         mul_req;
  data_t            mul_res;
  div_req_t         div_req;
  div_stat_t        div_stat;
  logic [QUO_W-1:0] div_quo;

  data_t            lim_pos;
  logic             div_sat;
  data_t            div_mag;
  data_t            div_drive;

  ladrc_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .res (mul_res)
  );

  ladrc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  assign lim_pos   = data_t'({1'b0, lim_r});
  assign div_sat   = div_stat.over || (div_quo > lim_r);
  assign div_mag   = div_sat ? lim_pos : data_t'({1'b0, div_quo});
  assign div_drive = (num_r[DATA_W-1] ^ plant_r[DATA_W-1]) ? -div_mag : div_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    z1_nxt        = z1_r;
    z2_nxt        = z2_r;
    u_prev_nxt    = u_prev_r;
    cmd_nxt       = cmd_r;
    meas_nxt      = meas_r;
    e_nxt         = e_r;
    beta1_nxt     = beta1_r;
    beta2_nxt     = beta2_r;
    m1_nxt        = m1_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    cdiff_nxt     = cdiff_r;
    num_nxt       = num_r;
    res_drive_nxt = res_drive_r;
    res_lim_nxt   = res_lim_r;
    out_valid_nxt = out_valid_r;
    out_drive_nxt = out_drive_r;
    out_lim_nxt   = out_lim_r;
    mul_req       = '{a: wide_t'(beta1_r), b: wide_t'(e_r), sh32: 1'b0};
    div_req       = '{start: 1'b0, num_mag: mag(num_r), den_mag: mag(plant_r)};

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt  = in_ch.speed_cmd;
          meas_nxt = in_ch.speed_meas;
          if (in_ch.clear) begin
            z1_nxt        = '0;
            z2_nxt        = '0;
            u_prev_nxt    = '0;
            res_drive_nxt = '0;
            res_lim_nxt   = 1'b0;
            state_nxt     = ST_OUT;
          end else begin
            state_nxt = ST_BETA2;
          end
        end
      end
      ST_BETA2: begin
        mul_req   = '{a: wide_t'({2'b00, obs_r}), b: wide_t'({2'b00, obs_r}), sh32: 1'b0};
        e_nxt     = sat_sub(z1_r, meas_r);
        beta1_nxt = obs_r[GAIN_W-1] ? DATA_MAX : data_t'({obs_r, 1'b0});
        state_nxt = ST_BETA1E;
      end
      ST_BETA1E: begin
        mul_req   = '{a: wide_t'(beta1_r), b: wide_t'(e_r), sh32: 1'b0};
        state_nxt = ST_PLANT;
      end
      ST_PLANT: begin
        mul_req   = '{a: wide_t'(plant_r), b: wide_t'(u_prev_r), sh32: 1'b0};
        beta2_nxt = mul_res;
        state_nxt = ST_BETA2E;
      end
      ST_BETA2E: begin
        mul_req   = '{a: wide_t'(beta2_r), b: wide_t'(e_r), sh32: 1'b0};
        m1_nxt    = mul_res;
        state_nxt = ST_D1A;
      end
      ST_D1A: begin
        d1_nxt    = sat_add(z2_r, mul_res);
        state_nxt = ST_D1B;
      end
      ST_D1B: begin
        d1_nxt    = sat_sub(d1_r, m1_r);
        d2_nxt    = sat_wide(-wide_t'(mul_res));
        state_nxt = ST_TSD1;
      end
      ST_TSD1: begin
        mul_req   = '{a: wide_t'({1'b0, period_r}), b: wide_t'(d1_r), sh32: 1'b1};
        state_nxt = ST_TSD2;
      end
      ST_TSD2: begin
        mul_req   = '{a: wide_t'({1'b0, period_r}), b: wide_t'(d2_r), sh32: 1'b1};
        state_nxt = ST_Z1;
      end
      ST_Z1: begin
        z1_nxt    = sat_add(z1_r, mul_res);
        state_nxt = ST_Z2;
      end
      ST_Z2: begin
        z2_nxt    = sat_add(z2_r, mul_res);
        cdiff_nxt = sat_sub(cmd_r, z1_r);
        state_nxt = ST_U0;
      end
      ST_U0: begin
        mul_req   = '{a: wide_t'({2'b00, ctrl_r}), b: wide_t'(cdiff_r), sh32: 1'b0};
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        state_nxt = ST_NUM;
      end
      ST_NUM: begin
        num_nxt   = sat_sub(mul_res, z2_r);
        state_nxt = ST_DIVSTART;
      end
      ST_DIVSTART: begin
        if (plant_r == '0) begin
          if (num_r == '0) begin
            res_drive_nxt = '0;
            res_lim_nxt   = 1'b0;
          end else begin
            res_drive_nxt = num_r[DATA_W-1] ? -lim_pos : lim_pos;
            res_lim_nxt   = 1'b1;
          end
          u_prev_nxt = res_drive_nxt;
          state_nxt  = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_drive_nxt = div_drive;
          res_lim_nxt   = div_sat;
          u_prev_nxt    = div_drive;
          state_nxt     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = res_drive_r;
          out_lim_nxt   = res_lim_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_r        <= '0;
      z2_r        <= '0;
      u_prev_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      z1_r        <= z1_nxt;
      z2_r        <= z2_nxt;
      u_prev_r    <= u_prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    meas_r      <= meas_nxt;
    e_r         <= e_nxt;
    beta1_r     <= beta1_nxt;
    beta2_r     <= beta2_nxt;
    m1_r        <= m1_nxt;
    d1_r        <= d1_nxt;
    d2_r        <= d2_nxt;
    cdiff_r     <= cdiff_nxt;
    num_r       <= num_nxt;
    res_drive_r <= res_drive_nxt;
    res_lim_r   <= res_lim_nxt;
    out_drive_r <= out_drive_nxt;
    out_lim_r   <= out_lim_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      plant_r  <= PLANT_RST;
      ctrl_r   <= GAIN_RST;
      obs_r    <= GAIN_RST;
      lim_r    <= GAIN_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PERIOD: period_r <= cfg_ch.data;
        CFG_PLANT:  plant_r  <= data_t'(cfg_ch.data);
        CFG_CTRL:   ctrl_r   <= cfg_ch.data[GAIN_W-1:0];
        CFG_OBS:    obs_r    <= cfg_ch.data[GAIN_W-1:0];
        CFG_LIMIT:  lim_r    <= cfg_ch.data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ch.ready   = 1'b1;
  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.drive   = out_drive_r;
  assign out_ch.limited = out_lim_r;

endmodule

[tb/ladrc_first_order_speed_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladrc_first_order_speed_tb: self-checking bench for the LADRC speed loop
// Drives control ticks and register writes over the valid/ready channels,
// predicts each drive and limit flag in fixed point, and compares every
// returned result in order under random source and sink stalls.
// ----------------------------------------------------------------------------
module ladrc_first_order_speed_tb;
  import ladrc_pkg::*;

  localparam longint Q_MAX       = longint'(DATA_MAX);
  localparam longint Q_MIN       = longint'(DATA_MIN);
  localparam int     CFG_COUNT   = int'(CFG_LIMIT) + 1;
  localparam int     IDX_SPAN    = 1 << CFG_IDX_W;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     SETTLE      = 64;
  localparam int     SEGMENTS    = 8;

  typedef struct {
    data_t drive;
    logic  limited;
  } drive_result_t;

  class drive_scoreboard;
    longint        period_q;
    longint        plant_q;
    longint        ctrl_q;
    longint        obs_q;
    longint        limit_q;
    longint        speed_est;
    longint        dist_est;
    longint        last_drive;
    drive_result_t pending_drives[$];
    int            error_count;

    function new();
      period_q    = longint'(PERIOD_RST);
      plant_q     = longint'(PLANT_RST);
      ctrl_q      = longint'(GAIN_RST);
      obs_q       = longint'(GAIN_RST);
      limit_q     = longint'(GAIN_RST);
      speed_est   = 0;
      dist_est    = 0;
      last_drive  = 0;
      error_count = 0;
    endfunction

    function longint clip(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    function logic [63:0] abs_q(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // exact product, round half away from zero, saturate
    function longint scaled_product(longint a, longint b, int sh);
      logic [127:0] p;
      bit           neg;
      neg = (a < 0) != (b < 0);
      p = {64'b0, abs_q(a)} * {64'b0, abs_q(b)};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      if (neg) begin
        if (p > 128'(Q_MAX + 1)) return Q_MIN;
        return -longint'(p[63:0]);
      end
      if (p > 128'(Q_MAX)) return Q_MAX;
      return longint'(p[63:0]);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        CFG_PERIOD: period_q = longint'({32'b0, val});
        CFG_PLANT:  plant_q  = longint'(data_t'(val));
        CFG_CTRL:   ctrl_q   = longint'({33'b0, val[GAIN_W-1:0]});
        CFG_OBS:    obs_q    = longint'({33'b0, val[GAIN_W-1:0]});
        CFG_LIMIT:  limit_q  = longint'({33'b0, val[GAIN_W-1:0]});
        default: ;
      endcase
    endfunction

    function drive_result_t predict_drive(longint cmd, longint meas, bit clr);
      longint        beta1, beta2, e, d1, d2, u0, num, q, u;
      drive_result_t res;
      res.drive   = '0;
      res.limited = 1'b0;
      if (clr) begin
        speed_est  = 0;
        dist_est   = 0;
        last_drive = 0;
        return res;
      end
      beta1 = clip(2 * obs_q);
      beta2 = scaled_product(obs_q, obs_q, FRAC_W);
      e  = clip(speed_est - meas);
      d1 = clip(dist_est + scaled_product(plant_q, last_drive, FRAC_W));
      d1 = clip(d1 - scaled_product(beta1, e, FRAC_W));
      d2 = clip(-scaled_product(beta2, e, FRAC_W));
      speed_est = clip(speed_est + scaled_product(period_q, d1, PERIOD_W));
      dist_est  = clip(dist_est + scaled_product(period_q, d2, PERIOD_W));
      u0  = scaled_product(ctrl_q, clip(cmd - speed_est), FRAC_W);
      num = clip(u0 - dist_est);
      if (plant_q == 0) begin
        if (num == 0) begin
          u = 0;
        end else begin
          u = (num > 0) ? limit_q : -limit_q;
          res.limited = 1'b1;
        end
      end else begin
        q = longint'((abs_q(num) << FRAC_W) / abs_q(plant_q));
        if (q > limit_q) begin
          q = limit_q;
          res.limited = 1'b1;
        end
        u = ((num < 0) != (plant_q < 0)) ? -q : q;
      end
      last_drive = u;
      res.drive  = data_t'(u);
      return res;
    endfunction

    function void note_request(data_t cmd, data_t meas, logic clr);
      pending_drives.push_back(predict_drive(cmd, meas, clr));
    endfunction

    task report_mismatch(string what);
      $display("%0t ns mismatch: %s", $time, what);
      error_count++;
    endtask

    task check_result(data_t drive, logic limited);
      drive_result_t want;
      if (pending_drives.size() == 0) begin
        report_mismatch($sformatf("drive %0d with no request outstanding", drive));
        return;
      end
      want = pending_drives.pop_front();
      if (drive !== want.drive)
        report_mismatch($sformatf("drive %0d, predicted %0d", drive, want.drive));
      if (limited !== want.limited)
        report_mismatch($sformatf("limited %b, predicted %b", limited, want.limited));
    endtask

    function int pending();
      return pending_drives.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   cycle_count;

  drive_scoreboard drive_sb = new();

  ladrc_in_if  in_ch ();
  ladrc_out_if out_ch ();
  ladrc_cfg_if cfg_ch ();

  ladrc_first_order_speed u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ladrc_first_order_speed_tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) drive_sb.check_result(out_ch.drive, out_ch.limited);
      if (in_ch.valid && in_ch.ready)
        drive_sb.note_request(in_ch.speed_cmd, in_ch.speed_meas, in_ch.clear);
      if (cfg_ch.valid && cfg_ch.ready) drive_sb.write_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  // leaves valid high on return; a hold lowers it, the next call may lower it
  task automatic send_tick(input data_t cmd, input data_t meas, input logic clr);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid      <= 1'b0;
      in_ch.speed_cmd  <= $urandom;
      in_ch.speed_meas <= $urandom;
      in_ch.clear      <= 1'($urandom_range(0, 1));
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.speed_cmd  <= cmd;
    in_ch.speed_meas <= meas;
    in_ch.clear      <= clr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (drive_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic apply_settings(input period_t ts, input data_t b0, input gain_t wc,
                                input gain_t wo, input gain_t lim);
    write_reg(CFG_PERIOD, ts);
    write_reg(CFG_PLANT, b0);
    write_reg(CFG_CTRL, {1'($urandom_range(0, 1)), wc});
    write_reg(CFG_OBS, {1'($urandom_range(0, 1)), wo});
    write_reg(CFG_LIMIT, {1'($urandom_range(0, 1)), lim});
    write_reg(CFG_IDX_W'(CFG_COUNT + $urandom_range(0, IDX_SPAN - CFG_COUNT - 1)), $urandom);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic pick_settings(input int seg);
    period_t ts;
    data_t   b0;
    gain_t   wc, wo, lim;
    ts  = $urandom_range(1 << 20, 1 << 28);
    b0  = $urandom_range(1 << 12, 1 << 22);
    wc  = gain_t'($urandom_range(1 << 14, 1 << 22));
    wo  = gain_t'($urandom_range(1 << 14, 1 << 22));
    lim = gain_t'($urandom_range(1 << 16, 1 << 28));
    if ($urandom_range(0, 1)) b0 = -b0;
    if ($urandom_range(0, 7) == 0) b0 = '0;
    if ($urandom_range(0, 7) == 0) lim = '1;
    case (seg)
      0: apply_settings('1, DATA_MIN, '1, '1, '1);
      1: apply_settings('0, 32'sd1, '0, '0, '0);
      2: apply_settings(PERIOD_RST, DATA_MAX, GAIN_RST, GAIN_RST, '1);
      3: apply_settings(ts, '0, wc, wo, lim);
      default: apply_settings(ts, b0, wc, wo, lim);
    endcase
  endtask

  task automatic send_random_tick();
    int    roll;
    int    span;
    data_t cmd, meas;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      send_tick($urandom, $urandom, 1'b1);
    end else if (roll < 13) begin
      send_tick($urandom, $urandom, 1'b0);
    end else begin
      span = 1 << $urandom_range(8, 28);
      cmd  = int'($urandom_range(0, 2 * span)) - span;
      meas = cmd + int'($urandom_range(0, span / 8)) - span / 16;
      send_tick(cmd, meas, 1'b0);
    end
  endtask

  initial begin
    int n_items;
    int pause_at;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.speed_cmd  <= '0;
    in_ch.speed_meas <= '0;
    in_ch.clear      <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_PERIOD;
    cfg_ch.data      <= '0;
    tx_idle_pct = 27;
    rx_idle_pct = 73;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_tick('0, '0, 1'b0);
    send_tick(DATA_MAX, DATA_MIN, 1'b0);
    send_tick(DATA_MIN, DATA_MAX, 1'b0);
    send_tick(DATA_MAX, DATA_MAX, 1'b0);
    send_tick(DATA_MIN, DATA_MIN, 1'b0);
    send_tick(DATA_MAX, DATA_MIN, 1'b1);
    send_tick(32'sd655360, '0, 1'b0);
    send_tick(-32'sd655360, '0, 1'b0);
    send_tick(32'sd32768, 32'sd16384, 1'b0);
    send_tick(-32'sd1, 32'sd1, 1'b0);
    send_tick('0, '0, 1'b1);
    hold_until_drained();

    apply_settings(PERIOD_RST, '0, GAIN_RST, GAIN_RST, GAIN_RST);
    send_tick('0, '0, 1'b1);
    send_tick('0, '0, 1'b0);
    send_tick(32'sd65536, '0, 1'b0);
    send_tick(-32'sd65536, '0, 1'b0);
    send_tick(DATA_MAX, DATA_MIN, 1'b0);
    hold_until_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 3) begin
        tx_idle_pct = 27;
        rx_idle_pct = 73;
      end else if (seg < 6) begin
        tx_idle_pct = 73;
        rx_idle_pct = 27;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick_settings(seg);
      n_items  = (seg < 2) ? 40 : 153;
      pause_at = $urandom_range(1, n_items - 1);
      for (int i = 0; i < n_items; i++) begin
        if (i == pause_at) hold_until_drained();
        send_random_tick();
      end
      hold_until_drained();
    end

    repeat (SETTLE) @(posedge clk);
    if (drive_sb.pending() != 0) drive_sb.report_mismatch("predicted drive never returned");
    if (drive_sb.error_count == 0) begin
      $display("ladrc_first_order_speed_tb: done, clean");
    end else begin
      $display("ladrc_first_order_speed_tb: done, errors");
    end
    $finish;
  end

endmodule
